// ===== rtl/core/eerl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Error event ring log package
// Shared constants and types for the error event ring log and its RAM.
// ----------------------------------------------------------------------------
package eerl_pkg;

    localparam int LOG_DEPTH_DEFAULT = 16;

    localparam int TIME_W  = 32;
    localparam int CODE_W  = 8;
    localparam int SEV_W   = 8;
    localparam int TASK_W  = 8;
    localparam int INDEX_W = 8;
    localparam int HELD_W  = 5;
    localparam int TOTAL_W = 32;
    localparam int ENTRY_W = TIME_W + CODE_W + TASK_W + SEV_W;

    // Task number stored when no task is running.
    localparam logic [TASK_W-1:0] NO_TASK = 8'hFF;

    typedef enum logic {
        OP_LOG  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef struct packed {
        logic [TIME_W-1:0] time_tick;
        logic [CODE_W-1:0] code;
        logic [TASK_W-1:0] task_num;
        logic [SEV_W-1:0]  sev;
    } t_entry;

endpackage
`default_nettype wire

// ===== rtl/core/eerl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds until the
// next read.
// ----------------------------------------------------------------------------
module eerl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/error_event_ring_log_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Error event ring log
// Circular log of error events held in one RAM, with read-back by age.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   i_valid / o_ready    i_op, i_time_tick, i_error_code, i_severity,
//                                 i_task_present, i_task_number, i_read_index
//  result    o_valid / i_ready    o_entry_*, o_entries_held, o_entries_total
//
// One request per cycle, but new requests are held off while a result
// waits for i_ready. A result appears in the cycle after acceptance, set
// by the registered read of the log RAM. A log request writes the RAM at the
// edge it is accepted, so a read in the next cycle already sees it. Reset
// clears head, counts and the result valid; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module error_event_ring_log_top #(
    parameter int LOG_DEPTH = eerl_pkg::LOG_DEPTH_DEFAULT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_op,
    input  wire logic [eerl_pkg::TIME_W-1:0]  i_time_tick,
    input  wire logic [eerl_pkg::CODE_W-1:0]  i_error_code,
    input  wire logic [eerl_pkg::SEV_W-1:0]   i_severity,
    input  wire logic                         i_task_present,
    input  wire logic [eerl_pkg::TASK_W-1:0]  i_task_number,
    input  wire logic [eerl_pkg::INDEX_W-1:0] i_read_index,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_entry_valid,
    output logic      [eerl_pkg::TIME_W-1:0]  o_entry_time,
    output logic      [eerl_pkg::CODE_W-1:0]  o_entry_code,
    output logic      [eerl_pkg::TASK_W-1:0]  o_entry_task,
    output logic      [eerl_pkg::SEV_W-1:0]   o_entry_severity,
    output logic      [eerl_pkg::HELD_W-1:0]  o_entries_held,
    output logic      [eerl_pkg::TOTAL_W-1:0] o_entries_total
);

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int KW = (CW > eerl_pkg::INDEX_W) ? CW : eerl_pkg::INDEX_W;
    localparam int HW = (CW > eerl_pkg::HELD_W) ? CW : eerl_pkg::HELD_W;

    logic [AW-1:0]                r_head, n_head;
    logic [CW-1:0]                r_held, n_held;
    logic [eerl_pkg::TOTAL_W-1:0] r_total, n_total;
    logic                         r_out_valid;
    logic                         r_hit;

    logic             accept;
    logic             is_log;
    logic             hit;
    logic [KW-1:0]    idx_ext;
    logic [KW-1:0]    held_ext;
    logic [SW-1:0]    pos_sum;
    logic [SW-1:0]    pos_wrap;
    logic [AW-1:0]    rd_addr;
    logic [HW-1:0]    held_out;
    eerl_pkg::t_entry wr_entry;
    eerl_pkg::t_entry rd_entry;
    logic [eerl_pkg::ENTRY_W-1:0] rd_data;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign is_log  = (eerl_pkg::t_op'(i_op) == eerl_pkg::OP_LOG);

    assign idx_ext  = KW'(i_read_index);
    assign held_ext = KW'(r_held);
    assign hit      = !is_log && (idx_ext < held_ext);

    // Slot of age idx is head - 1 - idx modulo the depth; the sum stays below
    // twice the depth whenever the read hits, so one subtract folds it.
    assign pos_sum  = SW'(r_head) + SW'(LOG_DEPTH - 1) - SW'(idx_ext[CW-1:0]);
    assign pos_wrap = (pos_sum >= SW'(LOG_DEPTH)) ? (pos_sum - SW'(LOG_DEPTH)) : pos_sum;
    assign rd_addr  = pos_wrap[AW-1:0];

    always_comb begin
        wr_entry.time_tick = i_time_tick;
        wr_entry.code      = i_error_code;
        wr_entry.task_num  = i_task_present ? i_task_number : eerl_pkg::NO_TASK;
        wr_entry.sev       = i_severity;
    end

    eerl_ram #(
        .WIDTH (eerl_pkg::ENTRY_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .i_clk   (i_clk),
        .i_we    (accept && is_log),
        .i_waddr (r_head),
        .i_wdata (wr_entry),
        .i_re    (accept && hit),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_head  = r_head;
        n_held  = r_held;
        n_total = r_total;
        if (accept && is_log) begin
            n_head  = (r_head == AW'(LOG_DEPTH - 1)) ? '0 : r_head + AW'(1);
            n_held  = (r_held == CW'(LOG_DEPTH)) ? r_held : r_held + CW'(1);
            n_total = r_total + eerl_pkg::TOTAL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_held      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_held  <= n_held;
            r_total <= n_total;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit <= hit;
        end
    end

    // Counts only move on acceptance, which also replaces the pending result,
    // so they stand for the result being shown.
    assign rd_entry         = rd_data;
    assign held_out         = HW'(r_held);
    assign o_valid          = r_out_valid;
    assign o_entry_valid    = r_hit;
    assign o_entry_time     = r_hit ? rd_entry.time_tick : '0;
    assign o_entry_code     = r_hit ? rd_entry.code : '0;
    assign o_entry_task     = r_hit ? rd_entry.task_num : '0;
    assign o_entry_severity = r_hit ? rd_entry.sev : '0;
    assign o_entries_held   = held_out[eerl_pkg::HELD_W-1:0];
    assign o_entries_total  = r_total;

endmodule
`default_nettype wire

// ===== tb/error_event_ring_log_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Error event ring log testbench
// Sends log and read-by-age requests with random gaps and random result
// stalls, including a long hold-off on the result side. A shadow copy of the
// ring predicts every result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module error_event_ring_log_top_tb;

    localparam int DEPTH         = eerl_pkg::LOG_DEPTH_DEFAULT;
    localparam int HALF_PERIOD   = 6;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int PRINT_LIMIT   = 200;

    typedef struct {
        eerl_pkg::t_op                        op;
        logic [eerl_pkg::TIME_W-1:0]  tick;
        logic [eerl_pkg::CODE_W-1:0]  code;
        logic [eerl_pkg::SEV_W-1:0]   sev;
        logic                         present;
        logic [eerl_pkg::TASK_W-1:0]  task_num;
        logic [eerl_pkg::INDEX_W-1:0] read_idx;
    } t_request;

    typedef struct {
        logic                         hit;
        logic [eerl_pkg::TIME_W-1:0]  tick;
        logic [eerl_pkg::CODE_W-1:0]  code;
        logic [eerl_pkg::TASK_W-1:0]  task_num;
        logic [eerl_pkg::SEV_W-1:0]   sev;
        logic [eerl_pkg::HELD_W-1:0]  held;
        logic [eerl_pkg::TOTAL_W-1:0] total;
    } t_readout;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_valid        = 1'b0;
    logic                         i_op           = eerl_pkg::OP_LOG;
    logic [eerl_pkg::TIME_W-1:0]  i_time_tick    = '0;
    logic [eerl_pkg::CODE_W-1:0]  i_error_code   = '0;
    logic [eerl_pkg::SEV_W-1:0]   i_severity     = '0;
    logic                         i_task_present = 1'b0;
    logic [eerl_pkg::TASK_W-1:0]  i_task_number  = '0;
    logic [eerl_pkg::INDEX_W-1:0] i_read_index   = '0;
    logic                         i_ready        = 1'b0;
    logic                         o_ready;
    logic                         o_valid;
    logic                         o_entry_valid;
    logic [eerl_pkg::TIME_W-1:0]  o_entry_time;
    logic [eerl_pkg::CODE_W-1:0]  o_entry_code;
    logic [eerl_pkg::TASK_W-1:0]  o_entry_task;
    logic [eerl_pkg::SEV_W-1:0]   o_entry_severity;
    logic [eerl_pkg::HELD_W-1:0]  o_entries_held;
    logic [eerl_pkg::TOTAL_W-1:0] o_entries_total;

    // Shadow copy of the ring, advanced once per accepted log request.
    eerl_pkg::t_entry             shadow_log [DEPTH];
    int unsigned                  shadow_head  = 0;
    int unsigned                  shadow_held  = 0;
    logic [eerl_pkg::TOTAL_W-1:0] shadow_total = '0;

    t_request            pending_requests [$];
    t_readout            expected_readouts [$];
    t_request            offered;

    int unsigned         issued_count   = 0;
    int unsigned         accept_count   = 0;
    int unsigned         result_count   = 0;
    int unsigned         mismatch_count = 0;

    int unsigned         send_gap     = 0;
    bit                  send_quiet   = 1'b0;
    int unsigned         results_seen = 0;
    int unsigned         stall_left   = 0;
    int unsigned         hold_left    = 0;
    int unsigned         next_hold_at = 150;
    bit                  recv_quiet   = 1'b0;

    error_event_ring_log_top #(
        .LOG_DEPTH(DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_time_tick     (i_time_tick),
        .i_error_code    (i_error_code),
        .i_severity      (i_severity),
        .i_task_present  (i_task_present),
        .i_task_number   (i_task_number),
        .i_read_index    (i_read_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_entry_valid   (o_entry_valid),
        .o_entry_time    (o_entry_time),
        .o_entry_code    (o_entry_code),
        .o_entry_task    (o_entry_task),
        .o_entry_severity(o_entry_severity),
        .o_entries_held  (o_entries_held),
        .o_entries_total (o_entries_total)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] ERROR: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d: %s = 0x%0h, wanted 0x%0h",
                                      result_count, name, got, want));
        end
    endtask

    function automatic t_readout predict_readout(input t_request rq);
        t_readout    r;
        int unsigned slot;
        r = '{default: '0};
        if (rq.op == eerl_pkg::OP_LOG) begin
            shadow_log[shadow_head] = '{time_tick: rq.tick, code: rq.code,
                                        task_num: rq.present ? rq.task_num
                                                             : eerl_pkg::NO_TASK,
                                        sev: rq.sev};
            shadow_head = (shadow_head + 1) % DEPTH;
            if (shadow_held < DEPTH) shadow_held++;
            shadow_total = shadow_total + 1'b1;
        end else if (rq.read_idx < shadow_held) begin
            slot = (shadow_head + DEPTH - 1 - rq.read_idx) % DEPTH;
            r.hit      = 1'b1;
            r.tick     = shadow_log[slot].time_tick;
            r.code     = shadow_log[slot].code;
            r.task_num = shadow_log[slot].task_num;
            r.sev      = shadow_log[slot].sev;
        end
        r.held  = shadow_held[eerl_pkg::HELD_W-1:0];
        r.total = shadow_total;
        return r;
    endfunction

    // Read requests carry random noise in the log fields, and log requests
    // a random index, so that the unused fields are shown to be ignored.
    function automatic t_request log_request(input logic [eerl_pkg::TIME_W-1:0] tick,
                                             input logic [eerl_pkg::CODE_W-1:0] code,
                                             input logic [eerl_pkg::SEV_W-1:0] sev,
                                             input logic present,
                                             input logic [eerl_pkg::TASK_W-1:0] task_num);
        t_request rq;
        rq.op       = eerl_pkg::OP_LOG;
        rq.tick     = tick;
        rq.code     = code;
        rq.sev      = sev;
        rq.present  = present;
        rq.task_num = task_num;
        rq.read_idx = eerl_pkg::INDEX_W'($urandom_range(0, 255));
        return rq;
    endfunction

    function automatic t_request read_request(input logic [eerl_pkg::INDEX_W-1:0] idx);
        t_request rq;
        rq.op       = eerl_pkg::OP_READ;
        rq.tick     = $urandom();
        rq.code     = eerl_pkg::CODE_W'($urandom_range(0, 255));
        rq.sev      = eerl_pkg::SEV_W'($urandom_range(0, 255));
        rq.present  = 1'($urandom_range(0, 1));
        rq.task_num = eerl_pkg::TASK_W'($urandom_range(0, 255));
        rq.read_idx = idx;
        return rq;
    endfunction

    function automatic t_request random_log();
        logic [eerl_pkg::TASK_W-1:0] task_num;
        task_num = ($urandom_range(0, 15) == 0) ? eerl_pkg::NO_TASK
                                                : eerl_pkg::TASK_W'($urandom_range(0, 254));
        return log_request($urandom(), eerl_pkg::CODE_W'($urandom_range(0, 255)),
                           eerl_pkg::SEV_W'($urandom_range(0, 255)),
                           $urandom_range(0, 3) != 0, task_num);
    endfunction

    function automatic int unsigned draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    // Request driver: a new request may be loaded once the offered one has
    // been taken, so valid stays high across back-to-back requests.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || accept_count == issued_count) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                offered = pending_requests.pop_front();
                i_op           <= offered.op;
                i_time_tick    <= offered.tick;
                i_error_code   <= offered.code;
                i_severity     <= offered.sev;
                i_task_present <= offered.present;
                i_task_number  <= offered.task_num;
                i_read_index   <= offered.read_idx;
                i_valid        <= 1'b1;
                issued_count++;
                if (issued_count % 64 == 0) send_quiet = ($urandom_range(0, 2) == 0);
                send_gap = draw_wait(send_quiet);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver: a random stall after each result, and now and then a
    // long hold-off so that the block backs up and stops taking requests.
    always @(negedge i_clk) begin
        if (result_count != results_seen) begin
            results_seen = result_count;
            if (results_seen % 64 == 0) recv_quiet = ($urandom_range(0, 2) == 0);
            stall_left = draw_wait(recv_quiet);
        end
        if (result_count >= next_hold_at) begin
            hold_left    = 400;
            next_hold_at = next_hold_at + 500;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_readout seen;
        t_readout want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                result_count++;
                seen = '{o_entry_valid, o_entry_time, o_entry_code, o_entry_task,
                         o_entry_severity, o_entries_held, o_entries_total};
                if (expected_readouts.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_count));
                end else begin
                    want = expected_readouts.pop_front();
                    check_field("entry_valid", 32'(seen.hit), 32'(want.hit));
                    check_field("entry_time", seen.tick, want.tick);
                    check_field("entry_code", 32'(seen.code), 32'(want.code));
                    check_field("entry_task", 32'(seen.task_num), 32'(want.task_num));
                    check_field("entry_severity", 32'(seen.sev), 32'(want.sev));
                    check_field("entries_held", 32'(seen.held), 32'(want.held));
                    check_field("entries_total", seen.total, want.total);
                end
            end
            // A result never leaves in the cycle its request is taken, so
            // predicting after the check keeps the queue in order.
            if (i_valid && o_ready) begin
                expected_readouts.push_back(predict_readout(offered));
                accept_count++;
            end
        end
    end

    initial begin : stimulus
        int unsigned roll;
        logic [eerl_pkg::INDEX_W-1:0] idx;

        // Reads of an empty log, then a log with no task and one at the
        // field maxima, and a present task that carries the number 0xFF.
        pending_requests.push_back(read_request(8'd0));
        pending_requests.push_back(read_request(8'd255));
        pending_requests.push_back(log_request('0, '0, '0, 1'b0, '0));
        pending_requests.push_back(log_request('1, '1, '1, 1'b1, 8'hFE));
        pending_requests.push_back(log_request(32'h5A5A_A5A5, 8'h3C, 8'hC3, 1'b1,
                                               eerl_pkg::NO_TASK));
        pending_requests.push_back(read_request(8'd0));
        pending_requests.push_back(read_request(8'd2));
        pending_requests.push_back(read_request(8'd3));
        // Fill past the depth so the head wraps and the count saturates.
        repeat (14) pending_requests.push_back(random_log());
        pending_requests.push_back(read_request(eerl_pkg::INDEX_W'(DEPTH - 1)));
        pending_requests.push_back(read_request(eerl_pkg::INDEX_W'(DEPTH)));
        pending_requests.push_back(read_request(8'd255));

        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 45) begin
                pending_requests.push_back(random_log());
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70) idx = eerl_pkg::INDEX_W'($urandom_range(0, DEPTH));
                else if (roll < 85) idx = eerl_pkg::INDEX_W'($urandom_range(0, 31));
                else idx = eerl_pkg::INDEX_W'($urandom_range(0, 255));
                pending_requests.push_back(read_request(idx));
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_requests.size() != 0 || accept_count != issued_count ||
               expected_readouts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && expected_readouts.size() == 0) begin
            $display("error_event_ring_log_top: match");
        end else begin
            $display("error_event_ring_log_top: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("error_event_ring_log_top: mismatch");
        $finish;
    end

endmodule
